>>> sv/tdp_pkg.sv
// -----------------------------------------------------------------------------
// Trial division primality test: shared definitions
// Microcode types, step and condition codes, and result constants.
// -----------------------------------------------------------------------------
package tdp_pkg;

   localparam int DEFAULT_NUMBER_WIDTH = 32;
   localparam int COUNT_WIDTH          = 10;
   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = 10'd1023;
   localparam int FIRST_DIVISOR        = 2;

   typedef logic [2:0] op_type;
   typedef logic [2:0] cond_type;
   typedef logic [2:0] step_type;

   // datapath operations
   localparam op_type OP_NOP      = 3'd0;
   localparam op_type OP_LOAD     = 3'd1;
   localparam op_type OP_DIV_INIT = 3'd2;
   localparam op_type OP_DIV_STEP = 3'd3;
   localparam op_type OP_COUNT    = 3'd4;
   localparam op_type OP_ADVANCE  = 3'd5;
   localparam op_type OP_REPORT   = 3'd6;

   // jump conditions
   localparam cond_type CND_NEXT      = 3'd0;
   localparam cond_type CND_ALWAYS    = 3'd1;
   localparam cond_type CND_NOT_START = 3'd2;
   localparam cond_type CND_SQ_GT_N   = 3'd3;
   localparam cond_type CND_BITS_LEFT = 3'd4;
   localparam cond_type CND_NOT_SAT   = 3'd5;

   // program steps
   localparam step_type STEP_IDLE     = 3'd0;
   localparam step_type STEP_TEST     = 3'd1;
   localparam step_type STEP_DIV_INIT = 3'd2;
   localparam step_type STEP_DIV_STEP = 3'd3;
   localparam step_type STEP_COUNT    = 3'd4;
   localparam step_type STEP_ADVANCE  = 3'd5;
   localparam step_type STEP_DONE     = 3'd6;

   typedef struct packed {
      op_type   op;
      cond_type cond;
      step_type target;
   } uword_type;

   typedef struct packed {
      op_type op;
   } ctrl_type;

   typedef struct packed {
      logic sq_gt_n;
      logic bits_left;
      logic count_sat;
   } status_type;

endpackage

>>> sv/tdp_sequencer.sv
// -----------------------------------------------------------------------------
// Trial division primality test: microcode sequencer
// Step counter, control store and conditional jump logic.
// -----------------------------------------------------------------------------
module tdp_sequencer (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  tdp_pkg::status_type  status,
   output tdp_pkg::ctrl_type    ctrl,
   output logic                 busy
);

   tdp_pkg::step_type  pc_ff;
   tdp_pkg::step_type  pc_in;
   tdp_pkg::uword_type word;
   logic               take;

   function automatic tdp_pkg::uword_type rom_word(input tdp_pkg::step_type pc);
      tdp_pkg::uword_type w;
      unique case (pc)
         tdp_pkg::STEP_IDLE: w = '{tdp_pkg::OP_LOAD, tdp_pkg::CND_NOT_START,
                                   tdp_pkg::STEP_IDLE};
         tdp_pkg::STEP_TEST: w = '{tdp_pkg::OP_NOP, tdp_pkg::CND_SQ_GT_N,
                                   tdp_pkg::STEP_DONE};
         tdp_pkg::STEP_DIV_INIT: w = '{tdp_pkg::OP_DIV_INIT, tdp_pkg::CND_NEXT,
                                       tdp_pkg::STEP_IDLE};
         tdp_pkg::STEP_DIV_STEP: w = '{tdp_pkg::OP_DIV_STEP, tdp_pkg::CND_BITS_LEFT,
                                       tdp_pkg::STEP_DIV_STEP};
         tdp_pkg::STEP_COUNT: w = '{tdp_pkg::OP_COUNT, tdp_pkg::CND_NEXT,
                                    tdp_pkg::STEP_IDLE};
         tdp_pkg::STEP_ADVANCE: w = '{tdp_pkg::OP_ADVANCE, tdp_pkg::CND_NOT_SAT,
                                      tdp_pkg::STEP_TEST};
         tdp_pkg::STEP_DONE: w = '{tdp_pkg::OP_REPORT, tdp_pkg::CND_ALWAYS,
                                   tdp_pkg::STEP_IDLE};
         default: w = '{tdp_pkg::OP_NOP, tdp_pkg::CND_ALWAYS, tdp_pkg::STEP_IDLE};
      endcase
      return w;
   endfunction

   assign word = rom_word(pc_ff);
   assign busy = (pc_ff != tdp_pkg::STEP_IDLE);

   always_comb begin
      unique case (word.cond)
         tdp_pkg::CND_NEXT:      take = 1'b0;
         tdp_pkg::CND_ALWAYS:    take = 1'b1;
         tdp_pkg::CND_NOT_START: take = !start;
         tdp_pkg::CND_SQ_GT_N:   take = status.sq_gt_n;
         tdp_pkg::CND_BITS_LEFT: take = status.bits_left;
         tdp_pkg::CND_NOT_SAT:   take = !status.count_sat;
         default:                take = 1'b1;
      endcase
      pc_in = take ? word.target : pc_ff + 3'd1;
      // load only on a transfer
      if (word.op == tdp_pkg::OP_LOAD && !start) begin
         ctrl.op = tdp_pkg::OP_NOP;
      end else begin
         ctrl.op = word.op;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= tdp_pkg::STEP_IDLE;
      end else begin
         pc_ff <= pc_in;
      end
   end

endmodule

>>> sv/tdp_datapath.sv
// -----------------------------------------------------------------------------
// Trial division primality test: datapath
// Divisor and square tracking, bit-serial remainder, divisor count, result.
// -----------------------------------------------------------------------------
module tdp_datapath #(
   parameter int NUMBER_WIDTH = tdp_pkg::DEFAULT_NUMBER_WIDTH
) (
   input  logic                            clock,
   input  logic                            reset,
   input  tdp_pkg::ctrl_type               ctrl,
   input  logic [NUMBER_WIDTH-1:0]         req_number,
   output tdp_pkg::status_type             status,
   output logic                            rsp_valid,
   output logic                            rsp_is_prime,
   output logic [tdp_pkg::COUNT_WIDTH-1:0] rsp_divisor_count
);

   localparam int W  = NUMBER_WIDTH;
   localparam int DW = (NUMBER_WIDTH + 1) / 2 + 1;
   localparam int SW = NUMBER_WIDTH + 2;
   localparam int BW = $clog2(NUMBER_WIDTH);
   localparam int CW = tdp_pkg::COUNT_WIDTH;

   logic [W-1:0]  n_ff, n_in;
   logic [W-1:0]  q_ff, q_in;
   logic [DW-1:0] rem_ff, rem_in;
   logic [DW-1:0] d_ff, d_in;
   logic [SW-1:0] sq_ff, sq_in;
   logic [BW-1:0] bits_ff, bits_in;
   logic [CW-1:0] count_ff, count_in;
   logic          valid_ff, valid_in;
   logic          prime_ff, prime_in;
   logic [CW-1:0] out_count_ff, out_count_in;

   logic [DW:0]   trial;
   logic [DW:0]   d_ext;

   assign trial = {rem_ff, q_ff[W-1]};
   assign d_ext = {1'b0, d_ff};

   assign status.sq_gt_n   = sq_ff > {2'b00, n_ff};
   assign status.bits_left = (bits_ff != '0);
   assign status.count_sat = (count_ff == tdp_pkg::COUNT_MAX);

   always_comb begin
      n_in         = n_ff;
      q_in         = q_ff;
      rem_in       = rem_ff;
      d_in         = d_ff;
      sq_in        = sq_ff;
      bits_in      = bits_ff;
      count_in     = count_ff;
      valid_in     = 1'b0;
      prime_in     = prime_ff;
      out_count_in = out_count_ff;
      unique case (ctrl.op)
         tdp_pkg::OP_NOP: begin
         end
         tdp_pkg::OP_LOAD: begin
            n_in     = req_number;
            d_in     = DW'(tdp_pkg::FIRST_DIVISOR);
            sq_in    = SW'(tdp_pkg::FIRST_DIVISOR * tdp_pkg::FIRST_DIVISOR);
            count_in = '0;
         end
         tdp_pkg::OP_DIV_INIT: begin
            q_in    = n_ff;
            rem_in  = '0;
            bits_in = BW'(W - 1);
         end
         tdp_pkg::OP_DIV_STEP: begin
            // restoring step: shift in the next dividend bit, subtract if it fits
            if (trial >= d_ext) begin
               rem_in = DW'(trial - d_ext);
            end else begin
               rem_in = trial[DW-1:0];
            end
            q_in    = {q_ff[W-2:0], 1'b0};
            bits_in = bits_ff - BW'(1);
         end
         tdp_pkg::OP_COUNT: begin
            if (rem_ff == '0) begin
               count_in = count_ff + CW'(1);
            end
         end
         tdp_pkg::OP_ADVANCE: begin
            // (d+1)^2 = d^2 + 2d + 1
            sq_in = sq_ff + {{(SW - DW - 1){1'b0}}, d_ff, 1'b1};
            d_in  = d_ff + DW'(1);
         end
         tdp_pkg::OP_REPORT: begin
            valid_in     = 1'b1;
            prime_in     = (n_ff >= W'(tdp_pkg::FIRST_DIVISOR)) && (count_ff == '0);
            out_count_in = count_ff;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff         <= n_in;
      q_ff         <= q_in;
      rem_ff       <= rem_in;
      d_ff         <= d_in;
      sq_ff        <= sq_in;
      bits_ff      <= bits_in;
      count_ff     <= count_in;
      prime_ff     <= prime_in;
      out_count_ff <= out_count_in;
   end

   assign rsp_valid         = valid_ff;
   assign rsp_is_prime      = prime_ff;
   assign rsp_divisor_count = out_count_ff;

endmodule

>>> sv/trial_division_primality.sv
// -----------------------------------------------------------------------------
// Trial division primality test
// Tests one unsigned number per command by trying every divisor d >= 2 with
// d*d <= number; reports the divisor count (saturating) and a prime flag.
//
//   channel   ports                                   direction
//   command   start, busy, req_number                 in (busy out)
//   result    rsp_valid, rsp_is_prime,                out, one-cycle strobe
//             rsp_divisor_count
//
// Each divisor tried costs one full pass of the remainder unit, with at most
// floor(sqrt(number)) - 1 divisors tried; the remainder unit takes one
// dividend bit per cycle.
// Reset clears the step counter and the result strobe; no clearing pass.
// The receiver cannot stall: each result is shown for one cycle only.
// -----------------------------------------------------------------------------
module trial_division_primality #(
   parameter int NUMBER_WIDTH = tdp_pkg::DEFAULT_NUMBER_WIDTH
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic [NUMBER_WIDTH-1:0]         req_number,
   output logic                            rsp_valid,
   output logic                            rsp_is_prime,
   output logic [tdp_pkg::COUNT_WIDTH-1:0] rsp_divisor_count
);

   tdp_pkg::ctrl_type   ctrl;
   tdp_pkg::status_type status;

   tdp_sequencer u_seq (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .status (status),
      .ctrl   (ctrl),
      .busy   (busy)
   );

   tdp_datapath #(
      .NUMBER_WIDTH (NUMBER_WIDTH)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .ctrl              (ctrl),
      .req_number        (req_number),
      .status            (status),
      .rsp_valid         (rsp_valid),
      .rsp_is_prime      (rsp_is_prime),
      .rsp_divisor_count (rsp_divisor_count)
   );

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy did not rise after a command transfer");

   a_result_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result shown while the sequencer is busy");

   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held for more than one cycle");

   a_prime_no_div: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_is_prime) |-> (rsp_divisor_count == '0))
      else $error("prime reported with a nonzero divisor count");

endmodule

>>> test/testbench.sv
// -----------------------------------------------------------------------------
// Trial division primality test: testbench
// Sends numbers over the start/busy command port and checks every prime flag
// and divisor count against a local trial-division predictor; typed rows of
// the short directed table, which comes first, carry their own verdict. Random
// numbers follow in three phases with different sender idling: mostly small
// values, some near perfect squares, and a few larger; long searches stay rare.
// -----------------------------------------------------------------------------
module testbench;

   localparam int NUMBER_WIDTH     = tdp_pkg::DEFAULT_NUMBER_WIDTH;
   localparam int CLOCK_HALF       = 10;
   localparam int RANDOM_PER_PHASE = 26;
   localparam int DRAIN_CYCLES     = 100;
   // worst item: every divisor up to 2^(W/2) tried, each a full remainder pass
   localparam int unsigned WATCHDOG_LIMIT =
      4 * ((NUMBER_WIDTH + 4) * (1 << (NUMBER_WIDTH / 2)) + 3);

   typedef struct packed {
      logic                            is_prime;
      logic [tdp_pkg::COUNT_WIDTH-1:0] divisor_count;
   } verdict_type;

   typedef struct packed {
      logic [NUMBER_WIDTH-1:0] number;
      verdict_type             verdict;
   } pending_type;

   typedef struct packed {
      logic [NUMBER_WIDTH-1:0] number;
      logic                    typed;
      verdict_type             verdict;
   } directed_row_type;

   localparam int DIRECTED_COUNT = 22;

   // rows with typed = 1 carry their own expected verdict
   directed_row_type directed_rows [DIRECTED_COUNT] = '{
      '{32'd0,          1'b1, '{1'b0, 10'd0}},
      '{32'd1,          1'b1, '{1'b0, 10'd0}},
      '{32'd2,          1'b1, '{1'b1, 10'd0}},
      '{32'd3,          1'b1, '{1'b1, 10'd0}},
      '{32'd4,          1'b1, '{1'b0, 10'd1}},
      '{32'd9,          1'b1, '{1'b0, 10'd1}},
      '{32'd16,         1'b1, '{1'b0, 10'd2}},
      '{32'd25,         1'b1, '{1'b0, 10'd1}},
      '{32'd97,         1'b1, '{1'b1, 10'd0}},
      '{32'd6,          1'b0, '{1'b0, 10'd0}},
      '{32'd8,          1'b0, '{1'b0, 10'd0}},
      '{32'd24,         1'b0, '{1'b0, 10'd0}},
      '{32'd35,         1'b0, '{1'b0, 10'd0}},
      '{32'd48,         1'b0, '{1'b0, 10'd0}},
      '{32'd99,         1'b0, '{1'b0, 10'd0}},
      '{32'd100,        1'b0, '{1'b0, 10'd0}},
      '{32'd255,        1'b0, '{1'b0, 10'd0}},
      '{32'd256,        1'b0, '{1'b0, 10'd0}},
      '{32'd65521,      1'b0, '{1'b0, 10'd0}},
      '{32'd720720,     1'b0, '{1'b0, 10'd0}},
      '{32'h00FF_FFFF,  1'b0, '{1'b0, 10'd0}},
      '{32'hFFFF_FFFF,  1'b0, '{1'b0, 10'd0}}
   };

   logic                            clock;
   logic                            reset;
   logic                            start;
   logic                            busy;
   logic [NUMBER_WIDTH-1:0]         req_number;
   logic                            rsp_valid;
   logic                            rsp_is_prime;
   logic [tdp_pkg::COUNT_WIDTH-1:0] rsp_divisor_count;

   pending_type pending_verdicts [$];
   int          idle_pct;
   int          mismatches;
   int          numbers_sent;
   int          results_checked;
   int          primes_seen;
   int unsigned stall_cycles;

   trial_division_primality #(
      .NUMBER_WIDTH(NUMBER_WIDTH)
   ) uut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_number(req_number),
      .rsp_valid(rsp_valid),
      .rsp_is_prime(rsp_is_prime),
      .rsp_divisor_count(rsp_divisor_count)
   );

   initial begin
      clock = 1'b0;
      forever #CLOCK_HALF clock = ~clock;
   end

   function automatic verdict_type trial_divide(input logic [NUMBER_WIDTH-1:0] value);
      logic [63:0] n;
      logic [63:0] d;
      int unsigned count;
      verdict_type verdict;
      n = 64'(value);
      count = 0;
      for (d = tdp_pkg::FIRST_DIVISOR; d <= n / d; d++) begin
         if (n % d == 0) begin
            count++;
            // stop once saturated, nothing can change after that
            if (count >= tdp_pkg::COUNT_MAX) begin
               count = tdp_pkg::COUNT_MAX;
               break;
            end
         end
      end
      verdict.is_prime      = (n >= tdp_pkg::FIRST_DIVISOR) && (count == 0);
      verdict.divisor_count = count[tdp_pkg::COUNT_WIDTH-1:0];
      return verdict;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      mismatches++;
   endtask

   // Hold start until the block takes the number, then log its verdict.
   task automatic test_number(input logic [NUMBER_WIDTH-1:0] value,
                              input verdict_type verdict);
      pending_type entry;
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start      <= 1'b1;
      req_number <= value;
      do @(posedge clock); while (busy);
      entry.number  = value;
      entry.verdict = verdict;
      pending_verdicts.push_back(entry);
      numbers_sent++;
   endtask

   always @(posedge clock) begin
      pending_type head;
      if (!reset && rsp_valid) begin
         if (pending_verdicts.size() == 0) begin
            report_mismatch($sformatf("result prime=%0b count=%0d with nothing pending",
                                      rsp_is_prime, rsp_divisor_count));
         end else begin
            head = pending_verdicts.pop_front();
            results_checked++;
            if (rsp_is_prime)
               primes_seen++;
            if (rsp_is_prime !== head.verdict.is_prime)
               report_mismatch($sformatf("number %0d: is_prime %0b, expected %0b",
                                         head.number, rsp_is_prime, head.verdict.is_prime));
            if (rsp_divisor_count !== head.verdict.divisor_count)
               report_mismatch($sformatf("number %0d: divisor_count %0d, expected %0d",
                                         head.number, rsp_divisor_count,
                                         head.verdict.divisor_count));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("Watchdog: no transfer for %0d cycles, %0d results pending",
                     stall_cycles, pending_verdicts.size());
            $display("Simulation FAILED");
            $finish;
         end
      end
   end

   initial begin
      logic [NUMBER_WIDTH-1:0] value;
      int unsigned             sel;
      int unsigned             root;
      mismatches      = 0;
      numbers_sent    = 0;
      results_checked = 0;
      primes_seen     = 0;
      stall_cycles    = 0;
      idle_pct        = 23;
      reset      = 1'b1;
      start      = 1'b0;
      req_number = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         test_number(directed_rows[i].number,
                     directed_rows[i].typed ? directed_rows[i].verdict
                                            : trial_divide(directed_rows[i].number));
      end

      for (int phase = 0; phase < 3; phase++) begin
         idle_pct = (phase == 0) ? 23 : (phase == 1) ? 64 : 0;
         repeat (RANDOM_PER_PHASE) begin
            sel = $urandom_range(99);
            // keep most searches short; a few reach a couple thousand divisors
            if (sel < 60) begin
               value = $urandom_range(4095);
            end else if (sel < 80) begin
               value = $urandom_range(65535);
            end else if (sel < 95) begin
               root  = $urandom_range(255, 2);
               value = root * root - 1 + $urandom_range(2);
            end else begin
               value = $urandom_range(1 << 22);
            end
            test_number(value, trial_divide(value));
         end
      end

      start <= 1'b0;
      while (pending_verdicts.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Tested %0d numbers (%0d results, %0d prime) including 0, 1 and all-ones,",
               numbers_sent, results_checked, primes_seen);
      $display("under light, heavy and no sender idling; %0d mismatches", mismatches);
      if (mismatches == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

>>> sim.f
sv/tdp_pkg.sv
sv/tdp_sequencer.sv
sv/tdp_datapath.sv
sv/trial_division_primality.sv
test/testbench.sv
